// ===== src/bmsp_pkg.sv =====
`default_nettype none
package bmsp_pkg;

    // paged ram geometry
    localparam int RAM_BYTES  = 131072;
    localparam int PAGE_BYTES = 16384;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);
    // bank * page + offset for bank up to 7 stays below 2^(PAGE_AW + 3)
    localparam int FULL_AW    = PAGE_AW + 3;

    // fixed bank of each window, the top window follows bank select
    localparam logic [2:0] BANK_WIN0 = 3'd0;
    localparam logic [2:0] BANK_WIN1 = 3'd5;
    localparam logic [2:0] BANK_WIN2 = 3'd2;

    // port decode
    localparam logic [15:0] PORT_READ_MASK  = 16'hC002;
    localparam logic [15:0] PORT_READ_MATCH = 16'hFFFD & 16'hC002;
    localparam logic [7:0]  PORT_READ_MISS  = 8'hFF;

    typedef enum logic [1:0] {
        REQ_MEM_RD  = 2'd0,
        REQ_MEM_WR  = 2'd1,
        REQ_PORT_WR = 2'd2,
        REQ_PORT_RD = 2'd3
    } t_req;

    // window to physical byte address, wrapping at the end of ram
    function automatic logic [RAM_AW-1:0] phys_addr(input logic [15:0] addr,
                                                    input logic [2:0]  sel_bank);
        logic [2:0]         bank;
        logic [FULL_AW-1:0] full;
        logic [FULL_AW:0]   wrapped;
        case (addr[15:14])
            2'd0:    bank = BANK_WIN0;
            2'd1:    bank = BANK_WIN1;
            2'd2:    bank = BANK_WIN2;
            default: bank = sel_bank;
        endcase
        full = {bank, addr[PAGE_AW-1:0]};
        // full is below twice the ram size, so one subtract does the modulo
        if ({1'b0, full} >= (FULL_AW+1)'(RAM_BYTES)) begin
            wrapped = {1'b0, full} - (FULL_AW+1)'(RAM_BYTES);
        end else begin
            wrapped = {1'b0, full};
        end
        return wrapped[RAM_AW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/banked_memory_and_sound_register_port.sv =====
// banked memory and sound register port
// input channel (i_in_valid / o_in_ready) takes one bus transfer: memory read,
// memory write, port write or port read, with address and write byte.
// output channel (o_out_valid / i_out_ready) returns exactly one result per
// transfer: read byte plus a report of any sound register write.
// memory accesses go to a 128 KiB single port ram; windows 0..2 map to fixed
// banks 0, 5 and 2, window 3 to the low bits of bank select.
// a transfer moves through stage 1 (ram access) and then the output register.
// throughput: one transfer per cycle while the receiver does not stall; output
// channel ready is the only pacing element, the ram read port never holds.
// a memory read in flight holds its data in the ram output register, so when
// the receiver stalls the pipe fills (one item in flight, one in the output)
// and then input ready drops until the output transfer happens.
// reset clears bank select, the selected register, all sound registers and
// the pipe valids; ram contents are left as they are (no clearing pass).
`default_nettype none
module banked_memory_and_sound_register_port
    import bmsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_wdata,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_rdata,
    output logic             o_snd_write,
    output logic [3:0]       o_snd_index,
    output logic [7:0]       o_snd_value
);

    // architectural registers
    logic [7:0] r_bank_select;
    logic [3:0] r_sel_reg;
    logic [7:0] r_snd_regs [16];

    // stage 1: ram access in flight, port results already known
    logic       r_s1_valid;
    logic       r_s1_mem_rd;
    logic [7:0] r_s1_rdata;
    logic       r_s1_snd_write;
    logic [3:0] r_s1_snd_index;
    logic [7:0] r_s1_snd_value;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic       r_out_snd_write;
    logic [3:0] r_out_snd_index;
    logic [7:0] r_out_snd_value;

    logic              in_xfer;
    logic              s1_adv;
    t_req              req;
    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_q;

    // decoded port write targets
    logic       pw_hit;
    logic       pw_bank;
    logic       pw_sel;
    logic       pw_snd;

    // next stage 1 payload
    logic [7:0] n_s1_rdata;
    logic       n_s1_snd_write;

    always_comb begin
        req     = t_req'(i_req_type);
        s1_adv  = r_s1_valid && (!r_out_valid || i_out_ready);
        // stage 1 frees when it moves on; the ram read data is held until then
        // nothing is taken while reset is held
        o_in_ready = i_rst_n && (!r_s1_valid || s1_adv);
        in_xfer = i_in_valid && o_in_ready;

        ram_addr = phys_addr(i_addr, r_bank_select[2:0]);
        ram_we   = in_xfer && (req == REQ_MEM_WR);
        ram_re   = in_xfer && (req == REQ_MEM_RD);

        pw_hit  = (req == REQ_PORT_WR) && !i_addr[1];
        pw_bank = pw_hit && !i_addr[15];
        pw_sel  = pw_hit && i_addr[15] && i_addr[14];
        pw_snd  = pw_hit && i_addr[15] && !i_addr[14];

        n_s1_snd_write = pw_snd;
        if (req == REQ_PORT_RD) begin
            if ((i_addr & PORT_READ_MASK) == PORT_READ_MATCH) begin
                n_s1_rdata = r_snd_regs[r_sel_reg];
            end else begin
                n_s1_rdata = PORT_READ_MISS;
            end
        end else begin
            n_s1_rdata = 8'h00;
        end
    end

    bmsp_ram #(
        .AW    (RAM_AW),
        .DW    (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_wdata),
        .o_rdata (ram_q)
    );

    // control state, sound registers and pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= 8'h00;
            r_sel_reg     <= 4'h0;
            for (int i = 0; i < 16; i++) begin
                r_snd_regs[i] <= 8'h00;
            end
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer && pw_bank) begin
                r_bank_select <= i_wdata;
            end
            if (in_xfer && pw_sel) begin
                r_sel_reg <= i_wdata[3:0];
            end
            if (in_xfer && pw_snd) begin
                r_snd_regs[r_sel_reg] <= i_wdata;
            end

            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_mem_rd    <= (req == REQ_MEM_RD);
            r_s1_rdata     <= n_s1_rdata;
            r_s1_snd_write <= n_s1_snd_write;
            r_s1_snd_index <= pw_snd ? r_sel_reg : 4'h0;
            r_s1_snd_value <= pw_snd ? i_wdata : 8'h00;
        end
        if (s1_adv) begin
            r_out_rdata     <= r_s1_mem_rd ? ram_q : r_s1_rdata;
            r_out_snd_write <= r_s1_snd_write;
            r_out_snd_index <= r_s1_snd_index;
            r_out_snd_value <= r_s1_snd_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_out_rdata;
    assign o_snd_write = r_out_snd_write;
    assign o_snd_index = r_out_snd_index;
    assign o_snd_value = r_out_snd_value;

endmodule
`default_nettype wire

// ===== src/bmsp_ram.sv =====
`default_nettype none
module bmsp_ram #(
    parameter int AW    = 17,
    parameter int DW    = 8,
    parameter int DEPTH = 131072
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire
